// ===== rtl/rtcm3_frame_validator_macros.svh =====
// assertion macros shared by the frame validator modules
`ifndef RTCM3_FRAME_VALIDATOR_MACROS_SVH
`define RTCM3_FRAME_VALIDATOR_MACROS_SVH

// checked only while out of reset
`define RFV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RFV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rtcm3v_pkg.sv =====
package rtcm3v_pkg;

    // frame format constants
    localparam logic [7:0]  PREAMBLE       = 8'hD3;
    localparam logic [7:0]  LEN_HI_MASK    = 8'h03;
    localparam logic [24:0] CRC_POLY       = 25'h1864CFB;
    localparam logic [10:0] COUNT_MAX      = 11'd2047;
    localparam logic [10:0] MIN_FRAME      = 11'd6;
    localparam logic [10:0] FRAME_OVERHEAD = 11'd6;

    // frame check outcome
    typedef enum logic [2:0] {
        ST_VALID        = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_PREAMBLE = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } t_status;

    // one result word
    typedef struct packed {
        t_status     status;
        logic [9:0]  payload_length;
        logic [23:0] computed_crc;
        logic [23:0] tail_crc;
    } t_result;

    // crc24q update by one byte, msb first
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

// ===== rtl/rtcm3v_tracker.sv =====
module rtcm3v_tracker
    import rtcm3v_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_result     o_result
);

`include "rtcm3_frame_validator_macros.svh"

    logic [10:0] r_byte_count;
    logic        r_preamble_ok;
    logic [9:0]  r_length_field;
    logic [23:0] r_crc;
    logic [7:0]  r_tail [3];

    logic [10:0] n_byte_count;
    logic        n_preamble_ok;
    logic [9:0]  n_length_field;
    logic [23:0] n_crc;
    logic [7:0]  len_hi;
    logic [23:0] rx_crc;
    logic [10:0] expected_total;

    // header capture and crc over the byte leaving the delay line
    always_comb begin
        len_hi         = i_data_byte & LEN_HI_MASK;
        n_preamble_ok  = r_preamble_ok;
        n_length_field = r_length_field;
        if (r_byte_count == 11'd0) begin
            n_preamble_ok = (i_data_byte == PREAMBLE);
        end else if (r_byte_count == 11'd1) begin
            n_length_field = {len_hi[1:0], r_length_field[7:0]};
        end else if (r_byte_count == 11'd2) begin
            n_length_field = {r_length_field[9:8], i_data_byte};
        end
        n_crc          = (r_byte_count >= 11'd3) ? crc24q_byte(r_crc, r_tail[2]) : r_crc;
        n_byte_count   = (r_byte_count < COUNT_MAX) ? r_byte_count + 11'd1 : r_byte_count;
        rx_crc         = {r_tail[1], r_tail[0], i_data_byte};
        expected_total = {1'b0, n_length_field} + FRAME_OVERHEAD;
    end

    // end-of-frame checks in priority order
    always_comb begin
        o_result.payload_length = n_length_field;
        o_result.computed_crc   = n_crc;
        o_result.tail_crc       = rx_crc;
        if (n_byte_count < MIN_FRAME) begin
            o_result.status         = ST_TOO_SHORT;
            o_result.payload_length = '0;
            o_result.computed_crc   = '0;
            o_result.tail_crc       = '0;
        end else if (!n_preamble_ok) begin
            o_result.status = ST_BAD_PREAMBLE;
        end else if (n_byte_count != expected_total) begin
            o_result.status = ST_LEN_MISMATCH;
        end else if (n_crc != rx_crc) begin
            o_result.status = ST_CRC_MISMATCH;
        end else begin
            o_result.status = ST_VALID;
        end
    end

    // frame state, back to empty after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_preamble_ok  <= 1'b0;
            r_length_field <= '0;
            r_crc          <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_byte_count   <= '0;
                r_preamble_ok  <= 1'b0;
                r_length_field <= '0;
                r_crc          <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_preamble_ok  <= n_preamble_ok;
                r_length_field <= n_length_field;
                r_crc          <= n_crc;
            end
        end
    end

    // tail delay line, newest in slot 0
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tail[2] <= r_tail[1];
            r_tail[1] <= r_tail[0];
            r_tail[0] <= i_data_byte;
        end
    end

    `RFV_ASSERT(a_frame_restart, (i_accept && i_last_byte) |=> (r_byte_count == 11'd0 && r_crc == 24'd0), "frame state not cleared after last byte")
    `RFV_ASSERT(a_crc_idle_in_header, (r_byte_count <= 11'd3) |-> (r_crc == 24'd0), "crc moved before the delay line filled")

endmodule

// ===== rtl/rtcm3_frame_validator.sv =====
// channel  direction  handshake                  word
// input    in         i_in_valid / o_in_ready    i_data_byte, i_last_byte
// result   out        o_out_valid / i_out_ready  o_status, o_payload_length,
//                                                o_computed_crc, o_tail_crc
//
// one byte per cycle while o_in_ready is high; the crc24q byte update sits between
// frame state and result register, so a status appears the cycle after its last byte
// a result waiting in the output register blocks input only while i_out_ready is low
// reset (synchronous, active low) empties the frame state and the output register
// non-final bytes give no result
module rtcm3_frame_validator
    import rtcm3v_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_payload_length,
    output logic [23:0] o_computed_crc,
    output logic [23:0] o_tail_crc
);

`include "rtcm3_frame_validator_macros.svh"

    logic    in_accept;
    t_result frame_result;
    logic    r_out_valid;
    t_result r_result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    rtcm3v_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (frame_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_byte) begin
            r_result <= frame_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_payload_length = r_result.payload_length;
    assign o_computed_crc   = r_result.computed_crc;
    assign o_tail_crc       = r_result.tail_crc;

    `RFV_ASSERT(a_result_from_last, $rose(o_out_valid) |-> $past(in_accept && i_last_byte), "result without a last byte")
    `RFV_ASSERT(a_valid_crc_match, (o_out_valid && o_status == ST_VALID) |-> (o_computed_crc == o_tail_crc), "valid status with crc mismatch")
    `RFV_ASSERT(a_short_zero, (o_out_valid && o_status == ST_TOO_SHORT) |-> ({o_payload_length, o_computed_crc, o_tail_crc} == '0), "short frame with nonzero fields")

endmodule

// ===== dv/rtcm3_frame_validator_tb.sv =====
`timescale 1ns / 1ps

module rtcm3_frame_validator_tb;
    import rtcm3v_pkg::*;

    typedef logic [7:0] t_frame_bytes[$];

    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned IDLE_MAX      = 17;
    localparam int unsigned RANDOM_BYTES  = 1200;
    localparam logic [23:0] CRC_TAPS      = CRC_POLY[23:0];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [9:0]  o_payload_length;
    logic [23:0] o_computed_crc;
    logic [23:0] o_tail_crc;

    // frame tracking state, mirrors the block
    logic [10:0] frame_pos;
    logic        lead_ok;
    logic [9:0]  hdr_length;
    logic [23:0] running_crc;
    logic [7:0]  trailer [3];

    t_result     pending_status[$];
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned sender_idle_max = IDLE_MAX;
    int unsigned sink_idle_max = IDLE_MAX;
    bit          hold_request = 1'b0;

    rtcm3_frame_validator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_computed_crc   (o_computed_crc),
        .o_tail_crc       (o_tail_crc)
    );

    always #10 i_clk = ~i_clk;

    // crc24q, one bit per pass, msb first
    function automatic logic [23:0] crc24q_update(input logic [23:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[23] ^ b[i];
            acc = {acc[22:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_TAPS;
            end
        end
        return acc;
    endfunction

    function automatic void clear_frame_state();
        frame_pos   = '0;
        lead_ok     = 1'b0;
        hdr_length  = '0;
        running_crc = '0;
        trailer     = '{default: 8'h00};
    endfunction

    // advance the frame state by one accepted byte, queue a status on the last one
    function automatic void track_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic [23:0] rx;
        if (frame_pos == 11'd0) begin
            lead_ok = (b == PREAMBLE);
        end else if (frame_pos == 11'd1) begin
            // only the low two bits carry length, the rest is reserved
            hdr_length[9:8] = b[1:0];
        end else if (frame_pos == 11'd2) begin
            hdr_length[7:0] = b;
        end
        // the oldest held-back byte drops into the crc
        if (frame_pos >= 11'd3) begin
            running_crc = crc24q_update(running_crc, trailer[2]);
        end
        trailer[2] = trailer[1];
        trailer[1] = trailer[0];
        trailer[0] = b;
        if (frame_pos != COUNT_MAX) begin
            frame_pos = frame_pos + 11'd1;
        end
        if (last) begin
            rx = {trailer[2], trailer[1], trailer[0]};
            if (frame_pos < MIN_FRAME) begin
                r.status         = ST_TOO_SHORT;
                r.payload_length = '0;
                r.computed_crc   = '0;
                r.tail_crc       = '0;
            end else begin
                if (!lead_ok) begin
                    r.status = ST_BAD_PREAMBLE;
                end else if (frame_pos != {1'b0, hdr_length} + FRAME_OVERHEAD) begin
                    r.status = ST_LEN_MISMATCH;
                end else if (running_crc != rx) begin
                    r.status = ST_CRC_MISMATCH;
                end else begin
                    r.status = ST_VALID;
                end
                r.payload_length = hdr_length;
                r.computed_crc   = running_crc;
                r.tail_crc       = rx;
            end
            pending_status.push_back(r);
            clear_frame_state();
        end
    endfunction

    // header, body of random bytes, then the crc trailer (one bit flipped when bad)
    function automatic t_frame_bytes make_frame(input logic [7:0] lead, input logic [9:0] len,
                                                input int unsigned body, input bit good_crc);
        t_frame_bytes f;
        logic [23:0]  crc;
        logic [5:0]   rsvd;
        rsvd = 6'($urandom_range(63, 0));
        f = {};
        f.push_back(lead);
        f.push_back({rsvd, len[9:8]});
        f.push_back(len[7:0]);
        for (int unsigned i = 0; i < body; i++) begin
            f.push_back(8'($urandom_range(255, 0)));
        end
        crc = '0;
        foreach (f[i]) begin
            crc = crc24q_update(crc, f[i]);
        end
        if (!good_crc) begin
            crc[$urandom_range(23, 0)] ^= 1'b1;
        end
        f.push_back(crc[23:16]);
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        return f;
    endfunction

    function automatic t_frame_bytes make_noise(input int unsigned n, input logic [7:0] lead);
        t_frame_bytes f;
        f = {lead};
        for (int unsigned i = 1; i < n; i++) begin
            f.push_back(8'($urandom_range(255, 0)));
        end
        return f;
    endfunction

    // offer one word after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = (sender_idle_max == 0) ? 0 : $urandom_range(sender_idle_max, 0);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_bytes f);
        foreach (f[i]) begin
            send_byte(f[i], i == f.size() - 1);
        end
    endtask

    task automatic test_short_frames();
        send_frame(make_noise(1, PREAMBLE));
        send_frame(make_noise(2, 8'h00));
        send_frame(make_noise(5, PREAMBLE));
    endtask

    task automatic test_good_frames();
        send_frame(make_frame(PREAMBLE, 10'd0, 0, 1'b1));
        send_frame(make_frame(PREAMBLE, 10'd4, 4, 1'b1));
    endtask

    task automatic test_bad_preamble();
        send_frame(make_frame(8'h00, 10'd2, 2, 1'b1));
        send_frame(make_frame(8'hD2, 10'd1, 1, 1'b0));
    endtask

    task automatic test_length_mismatch();
        send_frame(make_frame(PREAMBLE, 10'd5, 4, 1'b1));
        send_frame(make_frame(PREAMBLE, 10'd0, 1, 1'b1));
        // largest length field with a short body
        send_frame(make_frame(PREAMBLE, 10'd1023, 2, 1'b1));
    endtask

    task automatic test_crc_mismatch();
        send_frame(make_frame(PREAMBLE, 10'd3, 3, 1'b0));
    endtask

    // sink holds off while short frames keep coming, the input has to stall
    task automatic test_backpressure();
        sender_idle_max = 0;
        hold_request    = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_frame(make_frame(PREAMBLE, 10'd0, 0, i % 3 != 2));
        end
        sender_idle_max = IDLE_MAX;
    endtask

    task automatic test_random_frames();
        int unsigned  kind;
        int unsigned  body;
        logic [7:0]   lead;
        t_frame_bytes f;
        while (bytes_sent < RANDOM_BYTES) begin
            // some frames go with no idling on either side
            if ($urandom_range(4, 0) == 0) begin
                sender_idle_max = 0;
                sink_idle_max   = 0;
            end else begin
                sender_idle_max = IDLE_MAX;
                sink_idle_max   = IDLE_MAX;
            end
            kind = $urandom_range(99, 0);
            body = ($urandom_range(29, 0) == 0) ? $urandom_range(300, 0) : $urandom_range(20, 0);
            if (kind < 68) begin
                f = make_frame(PREAMBLE, 10'(body), body, 1'b1);
            end else if (kind < 78) begin
                f = make_frame(PREAMBLE, 10'(body), body, 1'b0);
            end else if (kind < 85) begin
                lead = 8'($urandom_range(255, 0));
                if (lead == PREAMBLE) begin
                    lead = 8'h00;
                end
                f = make_frame(lead, 10'(body), body, 1'($urandom_range(1, 0)));
            end else if (kind < 93) begin
                f = make_frame(PREAMBLE, 10'(body + $urandom_range(4, 1)), body, 1'b1);
            end else begin
                lead = $urandom_range(1, 0) ? PREAMBLE : 8'($urandom_range(255, 0));
                f = make_noise($urandom_range(12, 1), lead);
            end
            send_frame(f);
        end
        sender_idle_max = IDLE_MAX;
        sink_idle_max   = IDLE_MAX;
    endtask

    // result sink: random stall, then take one word and check it
    initial begin : result_sink
        int unsigned stall;
        t_result     want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = (sink_idle_max == 0) ? 0 : $urandom_range(sink_idle_max, 0);
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_status.size() == 0) begin
                $error("unexpected status word: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_status.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_payload_length !== want.payload_length) begin
                    $error("payload_length: expected %0d, got %0d",
                           want.payload_length, o_payload_length);
                    error_count++;
                end
                if (o_computed_crc !== want.computed_crc) begin
                    $error("computed_crc: expected %06h, got %06h",
                           want.computed_crc, o_computed_crc);
                    error_count++;
                end
                if (o_tail_crc !== want.tail_crc) begin
                    $error("tail_crc: expected %06h, got %06h",
                           want.tail_crc, o_tail_crc);
                    error_count++;
                end
            end
        end
    end

    initial begin
        clear_frame_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_good_frames();
        test_bad_preamble();
        test_length_mismatch();
        test_crc_mismatch();
        test_backpressure();
        test_random_frames();

        // drain, then keep watching the output for anything extra
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rtcm3_frame_validator_tb: done, clean");
        end else begin
            $display("rtcm3_frame_validator_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("rtcm3_frame_validator_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rtcm3v_pkg.sv
rtl/rtcm3v_tracker.sv
rtl/rtcm3_frame_validator.sv
dv/rtcm3_frame_validator_tb.sv
